@@ src/rcfq_pkg.sv @@
`timescale 1ns / 1ps

package rcfq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TAG_W = 16;
  localparam int DROP_W = 32;

  localparam logic [1:0] OP_SUBMIT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PURGE_L,
    S_PURGE_R,
    S_EVICT,
    S_INSERT,
    S_DONE
  } state_t;

  // Which queue entry to remove in this cycle.
  typedef enum logic [1:0] {
    RM_NONE,
    RM_LEFT,
    RM_RIGHT,
    RM_EVICT
  } rm_sel_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             rel_left;
    logic             rel_right;
    logic             rel_any;
  } entry_t;

  typedef struct packed {
    logic    load;
    logic    exec;
    rm_sel_t rm_sel;
    logic    drop_new;
    logic    insert;
  } cmd_t;

  typedef struct packed {
    logic submit_event;
    logic left_pending;
    logic right_pending;
    logic full;
    logic has_nonrel;
    logic new_rel_any;
  } status_t;

  // Lowest set bit of a mask; zero when the mask is empty.
  function automatic logic [IDX_W-1:0] first_set(input logic [QUEUE_DEPTH-1:0] mask);
    logic [IDX_W-1:0] pos;
    pos = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (mask[i]) begin
        pos = IDX_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

@@ src/release_coalescing_frame_queue.sv @@
`timescale 1ns / 1ps

// Frame queue with release coalescing. Pulse start while busy is low to issue
// one transaction (submit, pop, clear or no-op); the result appears in the
// cycle after the last internal step, on the result ports for one cycle with
// done high, and the receiver cannot stall it, so sample it then.
// Status ports (queue_count, latest_present, drop counters) are valid in the
// done cycle. Pop, clear, no-op, mailbox submits and submits ignored while
// disabled go through decode and then done. An event submit goes through
// decode, left and right release coalescing, evict, insert and done; in
// coalescing the queue controller removes the pending entries one per cycle
// through the shift network. An event submit that meets a full queue of
// releases with a plain newcomer discards the newcomer and skips the insert
// step. Write accept_enable only while busy is low.
module release_coalescing_frame_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_wdata,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode,
  input  logic [rcfq_pkg::TAG_W-1:0]  frame_tag,
  input  logic                        has_events,
  input  logic                        release_left,
  input  logic                        release_right,
  input  logic                        release_any,
  output logic                        done,
  output logic                        out_valid,
  output logic [rcfq_pkg::TAG_W-1:0]  out_tag,
  output logic                        out_from_queue,
  output logic [3:0]                  queue_count,
  output logic                        latest_present,
  output logic [rcfq_pkg::DROP_W-1:0] dropped_latest_count,
  output logic [rcfq_pkg::DROP_W-1:0] dropped_queue_count
);
  import rcfq_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence each transaction: decode, coalesce per hand, evict, insert.
  rcfq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Hold the queue entries, the mailbox, the drop counters and the result.
  rcfq_datapath u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .opcode               (opcode),
    .frame_tag            (frame_tag),
    .has_events           (has_events),
    .release_left         (release_left),
    .release_right        (release_right),
    .release_any          (release_any),
    .cmd                  (cmd),
    .status               (status),
    .out_valid            (out_valid),
    .out_tag              (out_tag),
    .out_from_queue       (out_from_queue),
    .queue_count          (queue_count),
    .latest_present       (latest_present),
    .dropped_latest_count (dropped_latest_count),
    .dropped_queue_count  (dropped_queue_count)
  );

endmodule

@@ src/rcfq_ctrl.sv @@
`timescale 1ns / 1ps

module rcfq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rcfq_pkg::status_t status,
  output rcfq_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done
);
  import rcfq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.rm_sel = RM_NONE;
    busy = (state != S_IDLE);
    done = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.submit_event) begin
          state_next = S_PURGE_L;
        end else begin
          cmd.exec = 1'b1;
          state_next = S_DONE;
        end
      end
      S_PURGE_L: begin
        if (status.left_pending) begin
          cmd.rm_sel = RM_LEFT;
        end else begin
          state_next = S_PURGE_R;
        end
      end
      S_PURGE_R: begin
        if (status.right_pending) begin
          cmd.rm_sel = RM_RIGHT;
        end else begin
          state_next = S_EVICT;
        end
      end
      S_EVICT: begin
        state_next = S_INSERT;
        if (status.full) begin
          if (status.has_nonrel || status.new_rel_any) begin
            cmd.rm_sel = RM_EVICT;
          end else begin
            cmd.drop_new = 1'b1;
            state_next = S_DONE;
          end
        end
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        done = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ src/rcfq_datapath.sv @@
`timescale 1ns / 1ps

module rcfq_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,
  input  logic [1:0]                      opcode,
  input  logic [rcfq_pkg::TAG_W-1:0]      frame_tag,
  input  logic                            has_events,
  input  logic                            release_left,
  input  logic                            release_right,
  input  logic                            release_any,
  input  rcfq_pkg::cmd_t                  cmd,
  output rcfq_pkg::status_t               status,
  output logic                            out_valid,
  output logic [rcfq_pkg::TAG_W-1:0]      out_tag,
  output logic                            out_from_queue,
  output logic [3:0]                      queue_count,
  output logic                            latest_present,
  output logic [rcfq_pkg::DROP_W-1:0]     dropped_latest_count,
  output logic [rcfq_pkg::DROP_W-1:0]     dropped_queue_count
);
  import rcfq_pkg::*;

  logic                    accept_enable;
  logic [1:0]              op;
  entry_t                  item;
  logic                    item_ev;
  entry_t                  queue [QUEUE_DEPTH];
  logic [CNT_W-1:0]        len;
  logic [TAG_W-1:0]        mailbox_tag;
  logic                    mailbox_full;
  logic [DROP_W-1:0]       latest_drops;
  logic [DROP_W-1:0]       queue_drops;

  logic [QUEUE_DEPTH-1:0]  live;
  logic [QUEUE_DEPTH-1:0]  left_mask;
  logic [QUEUE_DEPTH-1:0]  right_mask;
  logic [QUEUE_DEPTH-1:0]  nonrel_mask;
  logic                    pop_queue;
  logic                    shift_en;
  logic [IDX_W-1:0]        shift_pos;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      live[i]        = (CNT_W'(i) < len);
      left_mask[i]   = live[i] && queue[i].rel_left;
      right_mask[i]  = live[i] && queue[i].rel_right;
      nonrel_mask[i] = live[i] && !queue[i].rel_any;
    end
  end

  assign status.submit_event  = (op == OP_SUBMIT) && accept_enable && item_ev;
  assign status.left_pending  = item.rel_left && (|left_mask);
  assign status.right_pending = item.rel_right && (|right_mask);
  assign status.full          = (len == CNT_W'(QUEUE_DEPTH));
  assign status.has_nonrel    = |nonrel_mask;
  assign status.new_rel_any   = item.rel_any;

  assign pop_queue = cmd.exec && (op == OP_POP) && (len != '0);
  assign shift_en  = pop_queue || (cmd.rm_sel != RM_NONE);

  always_comb begin
    case (cmd.rm_sel)
      RM_LEFT:  shift_pos = first_set(left_mask);
      RM_RIGHT: shift_pos = first_set(right_mask);
      RM_EVICT: shift_pos = (|nonrel_mask) ? first_set(nonrel_mask) : '0;
      default:  shift_pos = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accept_enable <= 1'b0;
      len           <= '0;
      mailbox_full  <= 1'b0;
      latest_drops  <= '0;
      queue_drops   <= '0;
    end else begin
      if (cfg_we) begin
        accept_enable <= cfg_wdata;
      end
      if (cmd.load) begin
        op             <= opcode;
        item.tag       <= frame_tag;
        item.rel_left  <= release_left;
        item.rel_right <= release_right;
        item.rel_any   <= release_any;
        item_ev        <= has_events;
        out_valid      <= 1'b0;
        out_tag        <= '0;
        out_from_queue <= 1'b0;
      end
      // Close the gap left by a removed or popped entry.
      if (shift_en) begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          if (i >= int'(shift_pos)) begin
            queue[i] <= queue[i+1];
          end
        end
        len <= len - 1'b1;
      end
      if (cmd.rm_sel != RM_NONE || cmd.drop_new) begin
        queue_drops <= queue_drops + 1'b1;
      end
      if (cmd.insert) begin
        queue[len[IDX_W-1:0]] <= item;
        len <= len + 1'b1;
      end
      if (cmd.exec) begin
        case (op)
          OP_SUBMIT: begin
            if (accept_enable && !item_ev) begin
              if (mailbox_full) begin
                latest_drops <= latest_drops + 1'b1;
              end
              mailbox_tag  <= item.tag;
              mailbox_full <= 1'b1;
            end
          end
          OP_POP: begin
            if (len != '0) begin
              out_valid      <= 1'b1;
              out_tag        <= queue[0].tag;
              out_from_queue <= 1'b1;
            end else if (mailbox_full) begin
              out_valid    <= 1'b1;
              out_tag      <= mailbox_tag;
              mailbox_full <= 1'b0;
            end
          end
          OP_CLEAR: begin
            len          <= '0;
            mailbox_full <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign queue_count          = 4'(len);
  assign latest_present       = mailbox_full;
  assign dropped_latest_count = latest_drops;
  assign dropped_queue_count  = queue_drops;

endmodule

@@ tb/release_coalescing_frame_queue_tb.sv @@
`timescale 1ns / 1ps

module release_coalescing_frame_queue_tb;
  import rcfq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  // One submitted transaction, as driven on the input ports.
  typedef struct {
    logic [1:0]       op;
    logic [TAG_W-1:0] tag;
    logic             ev;
    logic             rel_l;
    logic             rel_r;
    logic             rel_a;
  } frame_op_t;

  // Everything the block reports in its done cycle.
  typedef struct {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic              from_q;
    logic [3:0]        count;
    logic              latest;
    logic [DROP_W-1:0] latest_drops;
    logic [DROP_W-1:0] queue_drops;
  } frame_res_t;

  // A line of the directed plan: either a register write or a transaction,
  // optionally with its result pinned by hand.
  typedef struct {
    bit         is_cfg;
    bit         cfg_val;
    frame_op_t  op;
    bit         pinned;
    frame_res_t want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              start = 1'b0;
  logic [1:0]        opcode = OP_NOP;
  logic [TAG_W-1:0]  frame_tag = '0;
  logic              has_events = 1'b0;
  logic              release_left = 1'b0;
  logic              release_right = 1'b0;
  logic              release_any = 1'b0;
  logic              busy;
  logic              done;
  logic              out_valid;
  logic [TAG_W-1:0]  out_tag;
  logic              out_from_queue;
  logic [3:0]        queue_count;
  logic              latest_present;
  logic [DROP_W-1:0] dropped_latest_count;
  logic [DROP_W-1:0] dropped_queue_count;

  release_coalescing_frame_queue dut (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .start                (start),
    .busy                 (busy),
    .opcode               (opcode),
    .frame_tag            (frame_tag),
    .has_events           (has_events),
    .release_left         (release_left),
    .release_right        (release_right),
    .release_any          (release_any),
    .done                 (done),
    .out_valid            (out_valid),
    .out_tag              (out_tag),
    .out_from_queue       (out_from_queue),
    .queue_count          (queue_count),
    .latest_present       (latest_present),
    .dropped_latest_count (dropped_latest_count),
    .dropped_queue_count  (dropped_queue_count)
  );

  always #4 clk = ~clk;

  // Shadow copy of the frame store, kept in step with every accepted
  // transaction. Index 0 of held_frames is the queue head.
  entry_t            held_frames[$];
  logic [TAG_W-1:0]  mbox_tag;
  bit                mbox_full;
  logic [DROP_W-1:0] mbox_drops;
  logic [DROP_W-1:0] evq_drops;
  bit                accept_en;

  frame_res_t        want_q[$];
  int                errors = 0;
  int unsigned       cycle_count = 0;
  bit                idle_on = 1'b1;
  plan_row_t         plan[$];

  // Drop every held entry that releases the given hand; count each removal.
  function automatic void coalesce_hand(input bit right_hand);
    int i;
    i = 0;
    while (i < held_frames.size()) begin
      if (right_hand ? held_frames[i].rel_right : held_frames[i].rel_left) begin
        held_frames.delete(i);
        evq_drops++;
      end else begin
        i++;
      end
    end
  endfunction

  // Advance the shadow store by one transaction and return what the block
  // should report for it.
  function automatic frame_res_t predict_frame(input frame_op_t f);
    frame_res_t r;
    entry_t     e;
    int         victim;
    bit         keep;
    r = '{default: '0};
    case (f.op)
      OP_SUBMIT: begin
        if (accept_en) begin
          if (f.ev) begin
            keep = 1'b1;
            if (f.rel_l) coalesce_hand(1'b0);
            if (f.rel_r) coalesce_hand(1'b1);
            if (held_frames.size() >= QUEUE_DEPTH) begin
              // Evict the oldest non-release entry; else refuse a
              // non-release newcomer; else give up the head.
              victim = -1;
              for (int i = 0; i < held_frames.size(); i++) begin
                if (victim < 0 && !held_frames[i].rel_any) victim = i;
              end
              evq_drops++;
              if (victim >= 0) held_frames.delete(victim);
              else if (!f.rel_a) keep = 1'b0;
              else held_frames.delete(0);
            end
            if (keep) begin
              e.tag = f.tag;
              e.rel_left = f.rel_l;
              e.rel_right = f.rel_r;
              e.rel_any = f.rel_a;
              held_frames = {held_frames, e};
            end
          end else begin
            if (mbox_full) mbox_drops++;
            mbox_tag = f.tag;
            mbox_full = 1'b1;
          end
        end
      end
      OP_POP: begin
        if (held_frames.size() > 0) begin
          e = held_frames[0];
          held_frames.delete(0);
          r.valid = 1'b1;
          r.tag = e.tag;
          r.from_q = 1'b1;
        end else if (mbox_full) begin
          r.valid = 1'b1;
          r.tag = mbox_tag;
          mbox_full = 1'b0;
        end
      end
      OP_CLEAR: begin
        held_frames.delete();
        mbox_full = 1'b0;
      end
      default: ;
    endcase
    r.count = 4'(held_frames.size());
    r.latest = mbox_full;
    r.latest_drops = mbox_drops;
    r.queue_drops = evq_drops;
    return r;
  endfunction

  function automatic plan_row_t stim_row(input logic [1:0] op, input logic [TAG_W-1:0] tag,
                                         input bit ev, input bit rl, input bit rr,
                                         input bit ra, input bit pinned,
                                         input bit v, input logic [TAG_W-1:0] t,
                                         input bit fq, input logic [3:0] cnt, input bit lat,
                                         input logic [DROP_W-1:0] dl,
                                         input logic [DROP_W-1:0] dq);
    plan_row_t p;
    p.is_cfg = 1'b0;
    p.cfg_val = 1'b0;
    p.op = '{op, tag, ev, rl, rr, ra};
    p.pinned = pinned;
    p.want = '{v, t, fq, cnt, lat, dl, dq};
    return p;
  endfunction

  function automatic plan_row_t cfg_row(input bit val);
    plan_row_t p;
    p = stim_row(OP_NOP, '0, 0, 0, 0, 0, 0, 0, '0, 0, '0, 0, '0, '0);
    p.is_cfg = 1'b1;
    p.cfg_val = val;
    return p;
  endfunction

  // Mostly well-formed traffic: more event submits than pops so the queue
  // fills up, hand releases normally flagged as releases too.
  function automatic frame_op_t rand_frame();
    frame_op_t f;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 58) f.op = OP_SUBMIT;
    else if (pick < 91) f.op = OP_POP;
    else if (pick < 94) f.op = OP_CLEAR;
    else f.op = OP_NOP;
    pick = $urandom_range(19);
    if (pick == 0) f.tag = '1;
    else if (pick == 1) f.tag = '0;
    else f.tag = TAG_W'($urandom);
    f.ev = ($urandom_range(99) < 80);
    f.rel_l = ($urandom_range(99) < 20);
    f.rel_r = ($urandom_range(99) < 20);
    if (f.rel_l || f.rel_r) f.rel_a = ($urandom_range(99) < 90);
    else f.rel_a = ($urandom_range(99) < 30);
    return f;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Present one transaction and hold it until accepted; log its expected
  // result. Start stays high on return so a follow-on can go back to back.
  task automatic issue(input frame_op_t f, input bit pinned, input frame_res_t pin_res);
    frame_res_t r;
    start <= 1'b1;
    opcode <= f.op;
    frame_tag <= f.tag;
    has_events <= f.ev;
    release_left <= f.rel_l;
    release_right <= f.rel_r;
    release_any <= f.rel_a;
    do @(posedge clk); while (busy);
    r = predict_frame(f);
    if (pinned) r = pin_res;
    want_q = {want_q, r};
  endtask

  // Idle the sender for a random gap about a third of the time.
  task automatic sender_gap();
    if (idle_on && $urandom_range(99) < 36) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Hold off until every outstanding result has come back and the block is
  // idle again.
  task automatic drain();
    start <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_accept(input bit val);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    accept_en = val;
  endtask

  // Score each done strobe against the oldest outstanding expectation.
  always @(posedge clk) begin
    frame_res_t w;
    if (!rst && done) begin
      if (want_q.size() == 0) begin
        $display("%0t: result with nothing outstanding, actual tag %h", $time, out_tag);
        errors++;
      end else begin
        w = want_q[0];
        want_q.delete(0);
        check_field("out_valid", 32'(w.valid), 32'(out_valid));
        check_field("out_tag", 32'(w.tag), 32'(out_tag));
        check_field("out_from_queue", 32'(w.from_q), 32'(out_from_queue));
        check_field("queue_count", 32'(w.count), 32'(queue_count));
        check_field("latest_present", 32'(w.latest), 32'(latest_present));
        check_field("dropped_latest_count", w.latest_drops, dropped_latest_count);
        check_field("dropped_queue_count", w.queue_drops, dropped_queue_count);
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    frame_res_t none;
    bit         phase_en[8];
    int         phase_len;
    phase_en = '{1, 0, 1, 1, 0, 1, 1, 1};
    none = '{default: '0};
    held_frames.delete();
    mbox_tag = '0;
    mbox_full = 1'b0;
    mbox_drops = '0;
    evq_drops = '0;
    accept_en = 1'b0;

    // Directed plan. Pinned rows are obvious by inspection; the rest are
    // scored against the shadow store.
    // Fresh from reset, still disabled: pop and no-op report nothing, and
    // submits of either kind are ignored.
    plan.push_back(stim_row(OP_POP, 16'h0000, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(stim_row(OP_NOP, 16'hFFFF, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(stim_row(OP_SUBMIT, 16'hFFFF, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(stim_row(OP_SUBMIT, 16'h0000, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(cfg_row(1'b1));
    // Mailbox: fill, overwrite (release flags ignored), then pop it.
    plan.push_back(stim_row(OP_SUBMIT, 16'h0000, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 0));
    plan.push_back(stim_row(OP_SUBMIT, 16'hFFFF, 0, 1, 1, 1, 1, 0, 0, 0, 0, 1, 1, 0));
    plan.push_back(stim_row(OP_POP, 16'h0000, 0, 0, 0, 0, 1, 1, 16'hFFFF, 0, 0, 0, 1, 0));
    // Fill the queue with releases only.
    plan.push_back(stim_row(OP_SUBMIT, 16'h0100, 1, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(stim_row(OP_SUBMIT, 16'h0101, 1, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 2; i < 8; i++) begin
      plan.push_back(stim_row(OP_SUBMIT, 16'h0100 + 16'(i), 1, 0, 0, 1,
                              0, 0, 0, 0, 0, 0, 0, 0));
    end
    // Full of releases: refuse a plain newcomer.
    plan.push_back(stim_row(OP_SUBMIT, 16'h0200, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Left release coalesces the older left release, then fits.
    plan.push_back(stim_row(OP_SUBMIT, 16'h0300, 1, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    // Full of releases, release newcomer: give up the head.
    plan.push_back(stim_row(OP_SUBMIT, 16'h0500, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(stim_row(OP_POP, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Plain entry fills the gap, then gets evicted as the oldest plain one.
    plan.push_back(stim_row(OP_SUBMIT, 16'h0600, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(stim_row(OP_SUBMIT, 16'h0700, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    // Both hands at once.
    plan.push_back(stim_row(OP_SUBMIT, 16'hFFFF, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(stim_row(OP_CLEAR, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(stim_row(OP_POP, 16'hFFFF, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(stim_row(OP_NOP, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    // Hold reset, then release it at a clock edge.
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_accept(plan[i].cfg_val);
      end else begin
        issue(plan[i].op, plan[i].pinned, plan[i].want);
        sender_gap();
      end
    end

    // Random phases, one accept setting each; phase 2 runs with no idling
    // and phase 5 stops once mid-way to let everything drain.
    for (int p = 0; p < 8; p++) begin
      write_accept(phase_en[p]);
      idle_on = (p != 2);
      phase_len = phase_en[p] ? 92 : 40;
      for (int n = 0; n < phase_len; n++) begin
        issue(rand_frame(), 1'b0, none);
        if ((p == 5 && n == phase_len / 2) || $urandom_range(99) == 0) drain();
        else sender_gap();
      end
    end

    // Wait out the last results plus some slack, then report.
    start <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
